### hw/rtl/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the barometric compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int RawW  = 20;
    localparam int CoefW = 16;
    localparam int TempW = 32;
    localparam int PresW = 32;
    localparam int StatW = 2;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;

    localparam int LimbW = 24;
    localparam int MulAW = 3 * LimbW;
    localparam int MulBW = 32;
    localparam int MulPW = MulAW + MulBW;

    localparam logic [CfgIdxW-1:0] CFG_TEMP  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PLOW  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PHIGH = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PLAST = 3'd3;

    typedef enum logic [StatW-1:0] {
        ST_OK         = 2'd0,
        ST_READ_FAULT = 2'd1,
        ST_DIV_FAULT  = 2'd2
    } t_status;

    typedef struct packed {
        logic            fault;
        logic [RawW-1:0] raw_t;
        logic [RawW-1:0] raw_p;
    } t_item;

    typedef struct packed {
        logic        [CoefW-1:0] t1;
        logic signed [CoefW-1:0] t2;
        logic signed [CoefW-1:0] t3;
        logic        [CoefW-1:0] p1;
        logic signed [CoefW-1:0] p2;
        logic signed [CoefW-1:0] p3;
        logic signed [CoefW-1:0] p4;
        logic signed [CoefW-1:0] p5;
        logic signed [CoefW-1:0] p6;
        logic signed [CoefW-1:0] p7;
        logic signed [CoefW-1:0] p8;
        logic signed [CoefW-1:0] p9;
    } t_coeffs;

endpackage

### hw/rtl/bsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_front
// Accepts raw readings, flags zero readings and queues them for the back end.
// ----------------------------------------------------------------------------
module bsc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [bsc_pkg::RawW-1:0] i_raw_temperature,
    input  logic [bsc_pkg::RawW-1:0] i_raw_pressure,
    output logic                     o_item_valid,
    input  logic                     i_item_ready,
    output bsc_pkg::t_item           o_item
);
    import bsc_pkg::*;

    t_item      r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_ready      = (r_count != 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rptr];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = o_item_valid && i_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (w_push) begin
            r_q[r_wptr].fault <= (i_raw_temperature == '0) || (i_raw_pressure == '0);
            r_q[r_wptr].raw_t <= i_raw_temperature;
            r_q[r_wptr].raw_p <= i_raw_pressure;
        end
    end

endmodule

### hw/rtl/bsc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_mul
// Shared signed multiplier: a wide operand times a 32-bit operand, one
// 24-bit limb per cycle with a registered partial product.
// ----------------------------------------------------------------------------
module bsc_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [bsc_pkg::MulAW-1:0] i_a,
    input  logic signed [bsc_pkg::MulBW-1:0] i_b,
    output logic                             o_done,
    output logic signed [bsc_pkg::MulPW-1:0] o_prod
);
    import bsc_pkg::*;

    logic signed [MulAW-1:0]       r_a;
    logic signed [MulBW-1:0]       r_b;
    logic [1:0]                    r_cnt;
    logic                          r_busy;
    logic signed [LimbW+MulBW:0]   r_pp;
    logic [1:0]                    r_ppk;
    logic                          r_ppv;
    logic signed [MulPW-1:0]       r_acc;
    logic                          r_done;
    logic signed [LimbW:0]         w_limb;
    logic signed [LimbW+MulBW:0]   w_pp;
    logic signed [MulPW-1:0]       w_add;

    always_comb begin
        case (r_cnt)
            2'd0:    w_limb = $signed({1'b0, r_a[LimbW-1:0]});
            2'd1:    w_limb = $signed({1'b0, r_a[2*LimbW-1:LimbW]});
            default: w_limb = $signed({r_a[MulAW-1], r_a[MulAW-1:2*LimbW]});
        endcase
        w_pp = w_limb * r_b;
        case (r_ppk)
            2'd0:    w_add = MulPW'(r_pp);
            2'd1:    w_add = MulPW'(r_pp) <<< LimbW;
            default: w_add = MulPW'(r_pp) <<< (2 * LimbW);
        endcase
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= r_ppv && (r_ppk == 2'd2);
            r_ppv  <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_ppv) begin
            r_acc <= r_acc + w_add;
        end
        if (r_busy) begin
            r_pp  <= w_pp;
            r_ppk <= r_cnt;
        end
    end

endmodule

### hw/rtl/bsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_back
// Sequencer that evaluates the compensation polynomials on the shared
// multiplier, runs the pressure division two bits a cycle and holds the
// result register.
// ----------------------------------------------------------------------------
module bsc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bsc_pkg::t_coeffs                  i_coeffs,
    input  logic                              i_item_valid,
    output logic                              o_item_ready,
    input  bsc_pkg::t_item                    i_item,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [bsc_pkg::StatW-1:0]         o_status,
    output logic signed [bsc_pkg::TempW-1:0]  o_temperature_centideg,
    output logic [bsc_pkg::PresW-1:0]         o_pressure_q24_8
);
    import bsc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_DIVEND, S_OUT} t_state;
    typedef enum logic [3:0] {
        OP_T1, OP_T2, OP_T3, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6, OP_P7,
        OP_Q1, OP_Q2, OP_Q3
    } t_op;

    t_state                  r_state;
    t_op                     r_op;
    t_item                   r_item;
    logic                    r_mstart;
    logic signed [MulAW-1:0] r_ma;
    logic signed [MulBW-1:0] r_mb;
    logic signed [23:0]      r_x1t;
    logic signed [24:0]      r_x1p;
    logic signed [49:0]      r_sq;
    logic signed [63:0]      r_acc2;
    logic signed [55:0]      r_acc1;
    logic                    r_neg;
    logic [38:0]             r_dvs;
    logic [75:0]             r_dvd;
    logic [75:0]             r_quo;
    logic [38:0]             r_rem;
    logic [5:0]              r_cnt;
    logic signed [41:0]      r_pq;
    logic signed [47:0]      r_x1q;
    t_status                 r_rst;
    logic signed [TempW-1:0] r_rtemp;
    logic [PresW-1:0]        r_rpres;
    logic                    r_ov;
    t_status                 r_ost;
    logic signed [TempW-1:0] r_otemp;
    logic [PresW-1:0]        r_opres;

    logic                    n_mstart;
    logic                    w_mdone;
    logic signed [MulPW-1:0] w_prod;
    logic signed [17:0]      w_dl;
    logic signed [24:0]      w_fine;
    logic signed [27:0]      w_f5;
    logic signed [24:0]      w_x1p;
    logic signed [55:0]      w_a;
    logic signed [39:0]      w_den;
    logic signed [21:0]      w_pa;
    logic signed [63:0]      w_num;
    logic signed [MulAW-1:0] w_nabs;
    logic [39:0]             w_r1;
    logic                    w_ge1;
    logic [38:0]             w_r1s;
    logic [39:0]             w_r2;
    logic                    w_ge2;
    logic [38:0]             w_r2s;
    logic [40:0]             w_mag;
    logic signed [41:0]      w_p;
    logic signed [28:0]      w_q;
    logic signed [49:0]      w_sum;
    logic signed [49:0]      w_res;
    logic [PresW-1:0]        w_pres;

    bsc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    always_comb begin
        w_dl   = $signed({2'b00, r_item.raw_t[RawW-1:4]}) - $signed({2'b00, i_coeffs.t1});
        w_fine = 25'(r_x1t) + 25'(w_prod >>> 14);
        w_f5   = (28'(w_fine) <<< 2) + 28'(w_fine) + 28'sd128;
        w_x1p  = w_fine - 25'sd128000;
        w_a    = r_acc1 + (56'(w_prod) <<< 12) + (56'sd1 <<< 47);
        w_den  = 40'(w_prod >>> 33);
        w_pa   = 22'sd1048576 - $signed({2'b00, r_item.raw_p});
        w_num  = (64'(w_pa) <<< 31) - r_acc2;
        w_nabs = w_num[63] ? -MulAW'(w_num) : MulAW'(w_num);

        w_r1  = {r_rem, r_dvd[75]};
        w_ge1 = (w_r1 >= {1'b0, r_dvs});
        w_r1s = w_ge1 ? 39'(w_r1 - {1'b0, r_dvs}) : w_r1[38:0];
        w_r2  = {w_r1s, r_dvd[74]};
        w_ge2 = (w_r2 >= {1'b0, r_dvs});
        w_r2s = w_ge2 ? 39'(w_r2 - {1'b0, r_dvs}) : w_r2[38:0];

        w_mag = (r_quo > (76'd1 << 40)) ? (41'd1 << 40) : r_quo[40:0];
        w_p   = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        w_q   = 29'(w_p >>> 13);

        w_sum = 50'(r_pq) + 50'(r_x1q) + 50'(w_prod >>> 19);
        w_res = (w_sum >>> 8) + (50'(i_coeffs.p7) <<< 4);
        if (w_res[49]) begin
            w_pres = '0;
        end else if (|w_res[48:PresW]) begin
            w_pres = '1;
        end else begin
            w_pres = w_res[PresW-1:0];
        end

        case (r_state)
            S_IDLE: begin
                n_mstart = i_item_valid && !i_item.fault;
            end
            S_MUL: begin
                n_mstart = w_mdone
                         && ((r_op inside {OP_T1, OP_T2, OP_T3, OP_P1, OP_P2, OP_P3,
                                           OP_P4, OP_P5, OP_Q1, OP_Q2})
                             || (r_op == OP_P6 && w_den != '0));
            end
            S_DIVEND: begin
                n_mstart = 1'b1;
            end
            default: begin
                n_mstart = 1'b0;
            end
        endcase
    end

    assign o_item_ready           = (r_state == S_IDLE);
    assign o_valid                = r_ov;
    assign o_status               = r_ost;
    assign o_temperature_centideg = r_otemp;
    assign o_pressure_q24_8       = r_opres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_T1;
            r_mstart <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_mstart <= n_mstart;
            if (r_state == S_OUT && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item <= i_item;
                        if (i_item.fault) begin
                            r_rst   <= ST_READ_FAULT;
                            r_rtemp <= '0;
                            r_rpres <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                            r_op    <= OP_T1;
                            r_ma    <= MulAW'($signed({2'b00, i_item.raw_t[RawW-1:3]})
                                       - $signed({2'b00, i_coeffs.t1, 1'b0}));
                            r_mb     <= MulBW'(i_coeffs.t2);
                        end
                    end
                end
                S_MUL: begin
                    if (w_mdone) begin
                        case (r_op)
                            OP_T1: begin
                                r_x1t <= 24'(w_prod >>> 11);
                                r_ma  <= MulAW'(w_dl);
                                r_mb  <= MulBW'(w_dl);
                                r_op  <= OP_T2;
                            end
                            OP_T2: begin
                                r_ma <= MulAW'(w_prod >>> 12);
                                r_mb <= MulBW'(i_coeffs.t3);
                                r_op <= OP_T3;
                            end
                            OP_T3: begin
                                r_rtemp <= TempW'(w_f5 >>> 8);
                                r_x1p   <= w_x1p;
                                r_ma    <= MulAW'(w_x1p);
                                r_mb    <= MulBW'(w_x1p);
                                r_op    <= OP_P1;
                            end
                            OP_P1: begin
                                r_sq <= 50'(w_prod);
                                r_ma <= MulAW'(w_prod);
                                r_mb <= MulBW'(i_coeffs.p6);
                                r_op <= OP_P2;
                            end
                            OP_P2: begin
                                r_acc2 <= 64'(w_prod);
                                r_ma   <= MulAW'(r_x1p);
                                r_mb   <= MulBW'(i_coeffs.p5);
                                r_op   <= OP_P3;
                            end
                            OP_P3: begin
                                r_acc2 <= r_acc2 + (64'(w_prod) <<< 17)
                                        + (64'(i_coeffs.p4) <<< 35);
                                r_ma   <= MulAW'(r_sq);
                                r_mb   <= MulBW'(i_coeffs.p3);
                                r_op   <= OP_P4;
                            end
                            OP_P4: begin
                                r_acc1 <= 56'(w_prod >>> 8);
                                r_ma   <= MulAW'(r_x1p);
                                r_mb   <= MulBW'(i_coeffs.p2);
                                r_op   <= OP_P5;
                            end
                            OP_P5: begin
                                r_ma <= MulAW'(w_a);
                                r_mb <= MulBW'($signed({1'b0, i_coeffs.p1}));
                                r_op <= OP_P6;
                            end
                            OP_P6: begin
                                if (w_den == '0) begin
                                    r_rst    <= ST_DIV_FAULT;
                                    r_rpres  <= '0;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_neg <= w_num[63] ^ w_den[39];
                                    r_dvs <= w_den[39] ? 39'(-w_den) : w_den[38:0];
                                    r_ma  <= w_nabs;
                                    r_mb  <= MulBW'(3125);
                                    r_op  <= OP_P7;
                                end
                            end
                            OP_P7: begin
                                r_dvd    <= w_prod[75:0];
                                r_quo    <= '0;
                                r_rem    <= '0;
                                r_cnt    <= '0;
                                r_state  <= S_DIV;
                            end
                            OP_Q1: begin
                                r_ma <= MulAW'(w_prod);
                                r_mb <= MulBW'(i_coeffs.p9);
                                r_op <= OP_Q2;
                            end
                            OP_Q2: begin
                                r_x1q <= 48'(w_prod >>> 25);
                                r_ma  <= MulAW'(r_pq);
                                r_mb  <= MulBW'(i_coeffs.p8);
                                r_op  <= OP_Q3;
                            end
                            default: begin
                                r_rst    <= ST_OK;
                                r_rpres  <= w_pres;
                                r_state  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_dvd <= {r_dvd[73:0], 2'b00};
                    r_quo <= {r_quo[73:0], w_ge1, w_ge2};
                    r_rem <= w_r2s;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd37) begin
                        r_state <= S_DIVEND;
                    end
                end
                S_DIVEND: begin
                    r_pq     <= w_p;
                    r_ma     <= MulAW'(w_q);
                    r_mb     <= MulBW'(w_q);
                    r_op     <= OP_Q1;
                    r_state  <= S_MUL;
                end
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_ost   <= r_rst;
                        r_otemp <= r_rtemp;
                        r_opres <= r_rpres;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/barometric_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer calibration compensation of raw temperature and pressure readings.
// ----------------------------------------------------------------------------
// Each transaction of a raw temperature and raw pressure reading yields one
// result: status, temperature in signed hundredths of a degree and pressure
// in pascals as unsigned Q24.8. A two-entry queue takes readings while the
// back end works, so a new transaction is accepted whilst earlier ones are
// in progress or a result waits, while the queue has room. A valid reading
// takes thirteen products on the shared limb-serial multiplier, the
// two-bit-per-cycle pressure divider and a hand-over to the result register.
// A reading with a zero field skips these and returns a read-fault status.
// The user must write coefficients through the configuration channel only
// while the block is idle; the block itself does not enforce this.
module barometric_sensor_compensation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bsc_pkg::RawW-1:0]            i_raw_temperature,
    input  logic [bsc_pkg::RawW-1:0]            i_raw_pressure,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [bsc_pkg::StatW-1:0]           o_status,
    output logic signed [bsc_pkg::TempW-1:0]    o_temperature_centideg,
    output logic [bsc_pkg::PresW-1:0]           o_pressure_q24_8,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bsc_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [bsc_pkg::CfgDataW-1:0]        i_cfg_data
);
    import bsc_pkg::*;

    logic [47:0]      r_temp_coeffs;
    logic [63:0]      r_press_low;
    logic [63:0]      r_press_high;
    logic [CoefW-1:0] r_press_last;
    t_coeffs          w_coeffs;
    t_item            w_item;
    logic             w_item_valid;
    logic             w_item_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_low   <= '0;
            r_press_high  <= '0;
            r_press_last  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TEMP:  r_temp_coeffs <= i_cfg_data[47:0];
                CFG_PLOW:  r_press_low   <= i_cfg_data;
                CFG_PHIGH: r_press_high  <= i_cfg_data;
                CFG_PLAST: r_press_last  <= i_cfg_data[CoefW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_coeffs.t1 = r_temp_coeffs[15:0];
        w_coeffs.t2 = r_temp_coeffs[31:16];
        w_coeffs.t3 = r_temp_coeffs[47:32];
        w_coeffs.p1 = r_press_low[15:0];
        w_coeffs.p2 = r_press_low[31:16];
        w_coeffs.p3 = r_press_low[47:32];
        w_coeffs.p4 = r_press_low[63:48];
        w_coeffs.p5 = r_press_high[15:0];
        w_coeffs.p6 = r_press_high[31:16];
        w_coeffs.p7 = r_press_high[47:32];
        w_coeffs.p8 = r_press_high[63:48];
        w_coeffs.p9 = r_press_last;
    end

    bsc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .o_item_valid      (w_item_valid),
        .i_item_ready      (w_item_ready),
        .o_item            (w_item)
    );

    bsc_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_coeffs               (w_coeffs),
        .i_item_valid           (w_item_valid),
        .o_item_ready           (w_item_ready),
        .i_item                 (w_item),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_status               (o_status),
        .o_temperature_centideg (o_temperature_centideg),
        .o_pressure_q24_8       (o_pressure_q24_8)
    );

endmodule
